/* hdl/dtab_pkg.sv */
// Shared constants and control types for the depth test and alpha blend block.
// Used by dtab_ctrl, dtab_datapath and depth_test_alpha_blend.
package dtab_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(PIXELS);
  localparam int COUNT_W    = $clog2(PIXELS + 1);

  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 1;
  localparam int COORD_W = 9;
  localparam int DEPTH_W = 24;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 4 * CHAN_W;
  localparam int SUM_W   = 2 * CHAN_W;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;

  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic OP_FRAGMENT = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  typedef struct packed {
    logic load_in;
    logic calc_addr;
    logic mem_rd;
    logic calc_blend;
    logic write_frag;
    logic clear_wr;
    logic load_out;
  } dtab_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_of_frame;
    logic frame_empty;
    logic clear_last;
  } dtab_stat_t;

endpackage

/* hdl/dtab_ctrl.sv */
// Sequencer for the depth test and alpha blend block.
// Depends on dtab_pkg for the command and status structs.
module dtab_ctrl
  import dtab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dtab_stat_t stat,
  output dtab_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_CMP,
    S_WRITE,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state == S_IDLE) && in_valid;
    cmd.calc_addr  = (state == S_ADDR);
    cmd.mem_rd     = (state == S_READ);
    cmd.calc_blend = (state == S_CMP);
    cmd.write_frag = (state == S_WRITE);
    cmd.clear_wr   = (state == S_CLEAR);
    cmd.load_out   = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (stat.is_clear) begin
            state <= stat.frame_empty ? S_FINISH : S_CLEAR;
          end else if (stat.out_of_frame) begin
            state <= S_FINISH;
          end else begin
            state <= S_READ;
          end
        end
        S_READ:  state <= S_CMP;
        S_CMP:   state <= S_WRITE;
        S_WRITE: state <= S_FINISH;
        S_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/dtab_datapath.sv */
// Datapath: frame registers, framebuffer memories, depth compare, blend and result.
// Depends on dtab_pkg; driven by dtab_ctrl through dtab_cmd_t.
module dtab_datapath
  import dtab_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               operation,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [DEPTH_W-1:0] frag_depth,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic [CHAN_W-1:0]  alpha,
  input  dtab_cmd_t          cmd,
  output dtab_stat_t         stat,
  output logic               depth_passed,
  output logic               depth_updated,
  output logic               out_of_range,
  output logic               clear_done
);

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [CFG_W-1:0]   eff_w;
  logic [CFG_W-1:0]   eff_h;

  logic               op_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [DEPTH_W-1:0] z_q;
  logic [CHAN_W-1:0]  r_q;
  logic [CHAN_W-1:0]  g_q;
  logic [CHAN_W-1:0]  b_q;
  logic [CHAN_W-1:0]  a_q;

  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  clear_index;
  logic               oor;
  logic               oor_q;
  logic               pass;
  logic               upd;

  logic [DEPTH_W-1:0] depth_rd;
  logic [COLOR_W-1:0] colour_rd;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_g;
  logic [SUM_W-1:0]   sum_b;
  logic [CHAN_W-1:0]  inv_a;

  logic               depth_we;
  logic               colour_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DEPTH_W-1:0] depth_wd;
  logic [COLOR_W-1:0] colour_wd;

  logic [DEPTH_W-1:0] depth_mem [PIXELS];
  logic [COLOR_W-1:0] colour_mem [PIXELS];

  function automatic logic [CHAN_W-1:0] div255_sat(input logic [SUM_W-1:0] v);
    logic [CHAN_W-1:0] q1;
    logic [CHAN_W+1:0] rem;
    logic [CHAN_W:0]   q;
    q1  = v[SUM_W-1:CHAN_W];
    rem = (CHAN_W+2)'(v[CHAN_W-1:0]) + (CHAN_W+2)'(q1);
    q   = (rem >= (CHAN_W+2)'(255)) ? (CHAN_W+1)'(q1) + 1'b1 : (CHAN_W+1)'(q1);
    return q[CHAN_W] ? '1 : q[CHAN_W-1:0];
  endfunction

  assign eff_w = (32'(frame_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width;
  assign eff_h = (32'(frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_height;
  assign oor   = (CFG_W'(x_q) >= eff_w) || (CFG_W'(y_q) >= eff_h);
  assign inv_a = ~a_q;

  assign stat.is_clear     = (op_q == OP_CLEAR);
  assign stat.out_of_frame = oor;
  assign stat.frame_empty  = (eff_w == '0) || (eff_h == '0);
  assign stat.clear_last   = (COUNT_W'(clear_index) + 1'b1) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(512);
      frame_height <= CFG_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q <= operation;
      x_q  <= pixel_x;
      y_q  <= pixel_y;
      z_q  <= frag_depth;
      r_q  <= red;
      g_q  <= green;
      b_q  <= blue;
      a_q  <= alpha;
    end
    if (cmd.calc_addr) begin
      addr  <= ADDR_W'(y_q) * ADDR_W'(eff_w) + ADDR_W'(x_q);
      count <= COUNT_W'(eff_w) * COUNT_W'(eff_h);
      oor_q <= oor;
    end
    if (cmd.calc_blend) begin
      pass  <= z_q < depth_rd;
      sum_r <= SUM_W'(colour_rd[7:0]) * SUM_W'(inv_a) + SUM_W'(r_q) * SUM_W'(a_q)
               + SUM_W'(127);
      sum_g <= SUM_W'(colour_rd[15:8]) * SUM_W'(inv_a) + SUM_W'(g_q) * SUM_W'(a_q)
               + SUM_W'(127);
      sum_b <= SUM_W'(colour_rd[23:16]) * SUM_W'(inv_a) + SUM_W'(b_q) * SUM_W'(a_q)
               + SUM_W'(127);
    end
    if (cmd.write_frag) begin
      upd <= pass && a_q[CHAN_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_index <= '0;
    end else if (cmd.calc_addr) begin
      clear_index <= '0;
    end else if (cmd.clear_wr) begin
      clear_index <= stat.clear_last ? '0 : clear_index + 1'b1;
    end
  end

  always_comb begin
    if (cmd.clear_wr) begin
      wr_addr   = clear_index;
      depth_we  = 1'b1;
      colour_we = 1'b1;
      depth_wd  = FAR_DEPTH;
      colour_wd = {a_q, b_q, g_q, r_q};
    end else begin
      wr_addr   = addr;
      depth_we  = cmd.write_frag && pass && a_q[CHAN_W-1];
      colour_we = cmd.write_frag && pass;
      depth_wd  = z_q;
      colour_wd = {colour_rd[31:24], div255_sat(sum_b), div255_sat(sum_g), div255_sat(sum_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[wr_addr] <= depth_wd;
    end
    if (cmd.mem_rd) begin
      depth_rd <= depth_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (colour_we) begin
      colour_mem[wr_addr] <= colour_wd;
    end
    if (cmd.mem_rd) begin
      colour_rd <= colour_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      clear_done    <= (op_q == OP_CLEAR);
      out_of_range  <= (op_q == OP_FRAGMENT) && oor_q;
      depth_passed  <= (op_q == OP_FRAGMENT) && !oor_q && pass;
      depth_updated <= (op_q == OP_FRAGMENT) && !oor_q && upd;
    end
  end

endmodule

/* hdl/depth_test_alpha_blend.sv */
// Depth test and alpha blend raster output stage over an on-chip framebuffer.
// Top level: joins dtab_ctrl and dtab_datapath; depends on dtab_pkg.
//
// Input channel (in_valid/in_ready) carries one item: a fragment or a clear.
// Output channel (out_valid/out_ready) returns one result item per input item.
// Configuration: cfg_we writes cfg_data into frame_width (index 0) or
// frame_height (index 1) at the clock edge; write only while idle.
//
// One item is in flight at a time. A fragment walks address, read, compare,
// blend/write and result steps; the next item is taken only once the block
// is back in idle after the result step. The framebuffer has one write port,
// so a clear writes one pixel a cycle until every pixel of the frame is set.
// Out-of-frame fragments and empty-frame clears go from the address step
// straight to the result step.
// A stalled receiver holds the result in the output register; the block
// finishes the next item and waits until that register is free.
// Reset (rst, synchronous) returns control to idle and the frame size to
// 512 x 512; framebuffer contents stay undefined until a clear writes them.
module depth_test_alpha_blend
  import dtab_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [DEPTH_W-1:0] frag_depth,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic [CHAN_W-1:0]  alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               depth_passed,
  output logic               depth_updated,
  output logic               out_of_range,
  output logic               clear_done
);

  dtab_cmd_t  cmd;
  dtab_stat_t stat;

  dtab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtab_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .frag_depth    (frag_depth),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .cmd           (cmd),
    .stat          (stat),
    .depth_passed  (depth_passed),
    .depth_updated (depth_updated),
    .out_of_range  (out_of_range),
    .clear_done    (clear_done)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({clear_done, out_of_range, depth_passed}))
    else $error("result flags conflict");

  a_update_needs_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_updated |-> depth_passed)
    else $error("depth stored without a passing test");

  a_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !in_ready && !cmd.write_frag)
    else $error("clear write overlaps other work");

endmodule

/* sim/depth_test_alpha_blend_test.sv */
`timescale 1ns / 1ps
// Self-checking test for depth_test_alpha_blend: fragment and clear items in, one result per item.
// A framebuffer predictor in the scoreboard class computes each expected result.
// Depends on dtab_pkg and the depth_test_alpha_blend RTL.

package dtab_test_pkg;
  import dtab_pkg::*;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] z;
    logic [CHAN_W-1:0]  r, g, b, a;
  } raster_item_t;

  typedef struct packed {
    logic passed;
    logic updated;
    logic dropped;
    logic cleared;
  } raster_result_t;

  class fb_scoreboard;
    bit [CFG_W-1:0]   width_reg;
    bit [CFG_W-1:0]   height_reg;
    bit [DEPTH_W-1:0] depth_buf [PIXELS];
    bit [COLOR_W-1:0] colour_buf [PIXELS];
    raster_result_t   pending_results [$];
    int               errors;

    function new();
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      errors     = 0;
    endfunction

    function void set_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    function int unsigned frame_w();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int unsigned frame_h();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function bit [CHAN_W-1:0] blend(int unsigned old, int unsigned src, int unsigned a);
      int unsigned v;
      v = (old * (255 - a) + src * a + 127) / 255;
      return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    function void note_item(raster_item_t it);
      raster_result_t   res;
      int unsigned      w;
      int unsigned      h;
      int unsigned      idx;
      bit [COLOR_W-1:0] old;
      res = '0;
      w = frame_w();
      h = frame_h();
      if (it.operation == OP_CLEAR) begin
        for (int unsigned i = 0; i < w * h; i++) begin
          depth_buf[i]  = FAR_DEPTH;
          colour_buf[i] = {it.a, it.b, it.g, it.r};
        end
        res.cleared = 1'b1;
      end else if (it.x >= w || it.y >= h) begin
        res.dropped = 1'b1;
      end else begin
        idx = it.y * w + it.x;
        if (it.z < depth_buf[idx]) begin
          old = colour_buf[idx];
          colour_buf[idx] = {old[31:24], blend(old[23:16], it.b, it.a),
                             blend(old[15:8], it.g, it.a), blend(old[7:0], it.r, it.a)};
          res.passed = 1'b1;
          if (it.a > 127) begin
            depth_buf[idx] = it.z;
            res.updated = 1'b1;
          end
        end
      end
      pending_results = {pending_results, res};
    endfunction

    function void check_result(raster_result_t got);
      raster_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual passed=%0b updated=%0b",
                 $time, got.passed, got.updated,
                 " out_of_range=%0b clear_done=%0b", got.dropped, got.cleared);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected passed=%0b updated=%0b out_of_range=%0b clear_done=%0b",
                 $time, want.passed, want.updated, want.dropped, want.cleared);
        $display("%0t:           actual passed=%0b updated=%0b out_of_range=%0b clear_done=%0b",
                 $time, got.passed, got.updated, got.dropped, got.cleared);
      end
    endfunction
  endclass

endpackage

module depth_test_alpha_blend_test;
  import dtab_pkg::*;
  import dtab_test_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 530;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_we     = 1'b0;
  logic [CIDX_W-1:0]  cfg_index  = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]   cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               operation  = OP_FRAGMENT;
  logic [COORD_W-1:0] pixel_x    = '0;
  logic [COORD_W-1:0] pixel_y    = '0;
  logic [DEPTH_W-1:0] frag_depth = '0;
  logic [CHAN_W-1:0]  red        = '0;
  logic [CHAN_W-1:0]  green      = '0;
  logic [CHAN_W-1:0]  blue       = '0;
  logic [CHAN_W-1:0]  alpha      = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic               depth_passed;
  logic               depth_updated;
  logic               out_of_range;
  logic               clear_done;

  fb_scoreboard sb = new();
  bit           calm = 1'b0;
  int           cycles = 0;

  depth_test_alpha_blend dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({depth_passed, depth_updated, out_of_range, clear_done});
    out_ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  function automatic raster_item_t fragment_item(int unsigned x, int unsigned y, int unsigned z,
                                                 int unsigned r, int unsigned g, int unsigned b,
                                                 int unsigned a);
    raster_item_t it;
    it.operation = OP_FRAGMENT;
    it.x = COORD_W'(x);
    it.y = COORD_W'(y);
    it.z = DEPTH_W'(z);
    it.r = CHAN_W'(r);
    it.g = CHAN_W'(g);
    it.b = CHAN_W'(b);
    it.a = CHAN_W'(a);
    return it;
  endfunction

  function automatic raster_item_t clear_item(int unsigned r, int unsigned g, int unsigned b,
                                              int unsigned a);
    raster_item_t it;
    it = fragment_item($urandom, $urandom, $urandom, r, g, b, a);
    it.operation = OP_CLEAR;
    return it;
  endfunction

  task automatic send(raster_item_t it);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= it.operation;
    pixel_x    <= it.x;
    pixel_y    <= it.y;
    frag_depth <= it.z;
    red        <= it.r;
    green      <= it.g;
    blue       <= it.b;
    alpha      <= it.a;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    sb.set_register(REG_FRAME_WIDTH, CFG_W'(w));
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    sb.set_register(REG_FRAME_HEIGHT, CFG_W'(h));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned fw, fh, ew, eh, span, done, x, y, z, a, stored;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-sized frame: clear still reports, every fragment drops
    set_frame(0, 7);
    send(clear_item(8'h12, 8'h34, 8'h56, 8'h78));
    send(fragment_item(0, 0, 0, 255, 255, 255, 255));

    set_frame(1, 1);
    send(clear_item(0, 0, 0, 0));
    send(fragment_item(0, 0, 0, 255, 128, 1, 255));
    send(fragment_item(0, 0, 0, 9, 9, 9, 255));
    send(fragment_item(1, 0, 5, 1, 2, 3, 255));
    send(fragment_item(0, 1, 5, 1, 2, 3, 255));
    send(clear_item(255, 255, 255, 255));
    send(fragment_item(0, 0, FAR_DEPTH, 0, 0, 0, 255));
    send(fragment_item(0, 0, FAR_DEPTH - 1, 0, 100, 200, 127));
    send(fragment_item(0, 0, FAR_DEPTH - 2, 10, 20, 30, 128));
    send(fragment_item(0, 0, 0, 255, 0, 0, 0));
    send(fragment_item(0, 0, 0, 0, 255, 0, 1));

    // oversized registers saturate to the frame bounds
    set_frame(1023, 2);
    send(clear_item(1, 2, 3, 4));
    send(fragment_item(511, 1, 123456, 200, 100, 50, 200));
    send(fragment_item(511, 2, 0, 200, 100, 50, 200));
    set_frame(3, 1023);
    send(clear_item(250, 5, 128, 0));
    send(fragment_item(2, 511, 999, 7, 8, 9, 255));
    send(fragment_item(3, 0, 0, 7, 8, 9, 255));

    set_frame(512, 512);
    send(clear_item(8'haa, 8'h55, 8'hf0, 8'h0f));
    send(fragment_item(511, 511, 0, 255, 255, 255, 255));
    send(fragment_item(0, 0, FAR_DEPTH - 1, 0, 0, 0, 64));

    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          fw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
          fh = (fw == 0) ? $urandom_range(0, 40) : 0;
        end
        1: begin
          fw = $urandom_range(513, 1023);
          fh = $urandom_range(1, 3);
        end
        2: begin
          fw = $urandom_range(1, 3);
          fh = $urandom_range(513, 1023);
        end
        3: begin
          fw = $urandom_range(40, 96);
          fh = $urandom_range(40, 96);
        end
        default: begin
          fw = $urandom_range(1, 16);
          fh = $urandom_range(1, 16);
        end
      endcase
      set_frame(fw, fh);
      ew = sb.frame_w();
      eh = sb.frame_h();
      span = $urandom_range(15, 50);
      for (int i = 0; i < span && done < RANDOM_ITEMS; i++) begin
        calm = (done >= 200 && done < 300);
        if (i == 0 || $urandom_range(0, 99) < 8) begin
          send(clear_item($urandom, $urandom, $urandom, $urandom));
        end else if ((ew * eh == 0 || $urandom_range(0, 99) < 12) &&
                     (ew < MAX_WIDTH || eh < MAX_HEIGHT)) begin
          if (ew < MAX_WIDTH) begin
            x = $urandom_range(ew, MAX_WIDTH - 1);
            y = $urandom_range(0, MAX_HEIGHT - 1);
          end else begin
            x = $urandom_range(0, MAX_WIDTH - 1);
            y = $urandom_range(eh, MAX_HEIGHT - 1);
          end
          send(fragment_item(x, y, $urandom, $urandom, $urandom, $urandom, $urandom));
        end else begin
          x = $urandom_range(0, ew - 1);
          y = $urandom_range(0, eh - 1);
          stored = 32'(sb.depth_buf[y * ew + x]);
          case ($urandom_range(0, 5))
            0: z = $urandom;
            1: z = (stored == 0) ? 0 : stored - 1;
            2: z = stored;
            3: z = (stored >= FAR_DEPTH - 3) ? FAR_DEPTH : stored + $urandom_range(1, 3);
            4: z = $urandom_range(0, 1) ? 0 : FAR_DEPTH;
            default: z = $urandom_range(0, stored);
          endcase
          case ($urandom_range(0, 5))
            0: a = 0;
            1: a = 255;
            2: a = $urandom_range(127, 128);
            default: a = $urandom_range(0, 255);
          endcase
          send(fragment_item(x, y, z, $urandom, $urandom, $urandom, a));
        end
        done++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* depth_test_alpha_blend.f */
hdl/dtab_pkg.sv
hdl/dtab_ctrl.sv
hdl/dtab_datapath.sv
hdl/depth_test_alpha_blend.sv
sim/depth_test_alpha_blend_test.sv
